@@ src/srr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srr_pkg: shared definitions of the selective repeat receiver
// Field widths, reply codes, register indexes, reset values and the
// configuration bundle passed from the register block to the back end.
// ----------------------------------------------------------------------------
package srr_pkg;

   localparam int MAX_FRAMES_DEF = 4096;
   localparam int MAX_GAP        = 63;

   localparam int DATA_W     = 8;
   localparam int FRAME_W    = 12;
   localparam int TOTAL_W    = 13;
   localparam int WINDOW_W   = 6;
   localparam int KIND_W     = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int REG_BIT    = 2;

   localparam int QUEUE_DEPTH = 2;

   localparam int TOTAL_RESET_VAL  = 1;
   localparam int WINDOW_RESET_VAL = 8;

   localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NAK    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

   localparam logic REG_TOTAL  = 1'b0;
   localparam logic REG_WINDOW = 1'b1;

   typedef struct packed {
      logic                restart;
      logic [TOTAL_W-1:0]  total_frames;
      logic [WINDOW_W-1:0] window_size;
   } cfg_type;

endpackage
`default_nettype wire

@@ src/srr_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srr_fifo: frame number queue
// A short queue of checked frame numbers between the byte checker and the
// reply sequencer, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module srr_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       flush,
   input  logic                       push,
   input  logic [srr_pkg::FRAME_W-1:0] push_number,
   input  logic                       pop,
   output logic                       full,
   output logic                       head_valid,
   output logic [srr_pkg::FRAME_W-1:0] head_number
);
   import srr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [FRAME_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full        = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid  = (count_ff != '0);
   assign head_number = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({push, pop})
         2'b10: begin
            count_in = count_ff + CNT_W'(1);
         end
         2'b01: begin
            count_in = count_ff - CNT_W'(1);
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      if (flush) begin
         wr_ptr_in = '0;
         rd_ptr_in = '0;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_number;
      end
   end

endmodule
`default_nettype wire

@@ src/srr_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srr_front: frame byte checker
// Accepts frame bytes, keeps the running XOR check and queues the number of
// every frame whose check byte matches. Corrupt frames are dropped here.
// ----------------------------------------------------------------------------
module srr_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       restart,
   input  logic                       clearing,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [srr_pkg::DATA_W-1:0]  req_data_byte,
   input  logic                       req_last_byte,
   input  logic [srr_pkg::FRAME_W-1:0] req_frame_number,
   input  logic                       queue_full,
   output logic                       push,
   output logic [srr_pkg::FRAME_W-1:0] push_number
);
   import srr_pkg::*;

   logic [DATA_W-1:0] check_acc_ff, check_acc_in;
   logic              accept;

   assign req_ready   = !queue_full && !clearing;
   assign accept      = req_valid && req_ready;
   assign push        = accept && req_last_byte && (check_acc_ff == req_data_byte);
   assign push_number = req_frame_number;

   always_comb begin
      check_acc_in = check_acc_ff;
      if (restart) begin
         check_acc_in = '0;
      end else if (accept) begin
         check_acc_in = req_last_byte ? '0 : (check_acc_ff ^ req_data_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_acc_ff <= '0;
      end else begin
         check_acc_ff <= check_acc_in;
      end
   end

endmodule
`default_nettype wire

@@ src/srr_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srr_back: window tracker and reply sequencer
// Takes checked frame numbers from the queue, keeps the received map and the
// receive window, and issues the ACK, NAK and reject replies one per transfer.
// ----------------------------------------------------------------------------
module srr_back #(
   parameter int MAX_FRAMES = srr_pkg::MAX_FRAMES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  srr_pkg::cfg_type           cfg,
   input  logic                       q_valid,
   input  logic [srr_pkg::FRAME_W-1:0] q_number,
   output logic                       q_pop,
   output logic                       clearing,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [srr_pkg::KIND_W-1:0]  rsp_reply_kind,
   output logic [srr_pkg::FRAME_W-1:0] rsp_reply_frame,
   output logic                       rsp_last_reply,
   output logic                       rsp_session_done
);
   import srr_pkg::*;

   localparam int IDX_W    = $clog2(MAX_FRAMES);
   localparam int CNT_W    = $clog2(MAX_FRAMES + 1);
   localparam int CMP_W    = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
   localparam int TF_RST   = (TOTAL_RESET_VAL > MAX_FRAMES) ? MAX_FRAMES : TOTAL_RESET_VAL;
   localparam int WH_RESET =
      ((WINDOW_RESET_VAL < TF_RST) ? WINDOW_RESET_VAL : TF_RST) - 1;

   typedef enum logic [5:0] {
      S_CLEAR   = 6'b000001,
      S_IDLE    = 6'b000010,
      S_SLIDE_RD = 6'b000100,
      S_SLIDE   = 6'b001000,
      S_NAK     = 6'b010000,
      S_REPLY   = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   next_exp_ff, next_exp_in;
   logic [CNT_W-1:0]   win_low_ff, win_low_in;
   logic [CNT_W-1:0]   win_high_ff, win_high_in;
   logic [CNT_W-1:0]   nak_ff, nak_in;
   logic [FRAME_W-1:0] num_ff, num_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;

   logic               map_mem [MAX_FRAMES];
   logic               map_rd_ff;
   logic               map_we;
   logic               map_wbit;
   logic [IDX_W-1:0]   map_waddr;
   logic [IDX_W-1:0]   map_raddr;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic [FRAME_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_done_ff, rsp_done_in;

   logic [CMP_W-1:0]   tf_raw, tf_clamp, ws_c, reload_c, q_c, ne_c, num_c;
   logic [CNT_W-1:0]   tf_eff, reload, q_cnt, num_cnt;
   logic               reject, finished, advance, out_free, load;

   assign tf_raw   = CMP_W'(cfg.total_frames);
   assign tf_clamp = (tf_raw == '0) ? CMP_W'(1) :
                     ((tf_raw > CMP_W'(MAX_FRAMES)) ? CMP_W'(MAX_FRAMES) : tf_raw);
   assign tf_eff   = tf_clamp[CNT_W-1:0];
   assign ws_c     = (cfg.window_size == '0) ? CMP_W'(1) : CMP_W'(cfg.window_size);
   assign reload_c = (ws_c < tf_clamp) ? (ws_c - CMP_W'(1)) : (tf_clamp - CMP_W'(1));
   assign reload   = reload_c[CNT_W-1:0];

   assign q_c     = CMP_W'(q_number);
   assign ne_c    = CMP_W'(next_exp_ff);
   assign q_cnt   = q_c[CNT_W-1:0];
   assign num_c   = CMP_W'(num_ff);
   assign num_cnt = num_c[CNT_W-1:0];
   assign reject  = (q_c >= tf_clamp) ||
                    ((q_c > ne_c) && ((q_c - ne_c) > CMP_W'(MAX_GAP)));

   assign finished = (win_low_ff == (win_high_ff + CNT_W'(1)));
   assign advance  = (win_low_ff <= win_high_ff) && map_rd_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign clearing = (state_ff == S_CLEAR);

   always_comb begin
      state_in     = state_ff;
      next_exp_in  = next_exp_ff;
      win_low_in   = win_low_ff;
      win_high_in  = win_high_ff;
      nak_in       = nak_ff;
      num_in       = num_ff;
      kind_in      = kind_ff;
      clr_in       = clr_ff;
      q_pop        = 1'b0;
      map_we       = 1'b0;
      map_wbit     = 1'b0;
      map_waddr    = clr_ff;
      load         = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_frame_in = rsp_frame_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;

      unique case (state_ff)
         S_CLEAR: begin
            map_we = 1'b1;
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(MAX_FRAMES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               num_in = q_number;
               if (reject) begin
                  kind_in  = KIND_REJECT;
                  state_in = S_REPLY;
               end else begin
                  map_we    = 1'b1;
                  map_wbit  = 1'b1;
                  map_waddr = q_cnt[IDX_W-1:0];
                  kind_in   = KIND_ACK;
                  if (q_cnt == next_exp_ff) begin
                     next_exp_in = next_exp_ff + CNT_W'(1);
                     state_in    = S_SLIDE_RD;
                  end else if (q_cnt > next_exp_ff) begin
                     nak_in      = next_exp_ff;
                     next_exp_in = q_cnt + CNT_W'(1);
                     state_in    = S_NAK;
                  end else begin
                     state_in = S_SLIDE_RD;
                  end
               end
            end
         end
         S_SLIDE_RD: begin
            state_in = S_SLIDE;
         end
         S_SLIDE: begin
            if (advance) begin
               win_low_in = win_low_ff + CNT_W'(1);
               if (win_high_ff < (tf_eff - CNT_W'(1))) begin
                  win_high_in = win_high_ff + CNT_W'(1);
               end
            end else begin
               state_in = S_REPLY;
            end
         end
         S_NAK: begin
            if (out_free) begin
               load         = 1'b1;
               rsp_kind_in  = KIND_NAK;
               rsp_frame_in = FRAME_W'(nak_ff);
               rsp_last_in  = 1'b0;
               rsp_done_in  = finished;
               nak_in       = nak_ff + CNT_W'(1);
               if ((nak_ff + CNT_W'(1)) == num_cnt) begin
                  state_in = S_REPLY;
               end
            end
         end
         S_REPLY: begin
            if (out_free) begin
               load         = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_frame_in = num_ff;
               rsp_last_in  = 1'b1;
               rsp_done_in  = finished;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase

      if (cfg.restart) begin
         state_in    = S_CLEAR;
         clr_in      = '0;
         next_exp_in = '0;
         win_low_in  = '0;
         win_high_in = reload;
      end
   end

   assign map_raddr    = win_low_in[IDX_W-1:0];
   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         next_exp_ff  <= '0;
         win_low_ff   <= '0;
         win_high_ff  <= CNT_W'(WH_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         next_exp_ff  <= next_exp_in;
         win_low_ff   <= win_low_in;
         win_high_ff  <= win_high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nak_ff       <= nak_in;
      num_ff       <= num_in;
      kind_ff      <= kind_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wbit;
      end
      map_rd_ff <= map_mem[map_raddr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_reply_kind   = rsp_kind_ff;
   assign rsp_reply_frame  = rsp_frame_ff;
   assign rsp_last_reply   = rsp_last_ff;
   assign rsp_session_done = rsp_done_ff;

endmodule
`default_nettype wire

@@ src/selective_repeat_receiver.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// selective_repeat_receiver: selective repeat ARQ receiver
// Frame bytes enter on the req channel, one transfer per byte, the check byte
// marked by req_last_byte. Replies leave on the rsp channel, one transfer per
// reply; every frame that passes its check ends with a reply that has
// rsp_last_reply set, a corrupt frame gives none.
// Bytes are taken one per cycle while req_ready is high. A checked frame
// waits in a two-entry queue; the back end then classifies it, for an
// in-order or late frame reads the registered read port of the received map,
// slides the window past each received frame and ends the slide, and then
// issues the frame's replies one at a time.
// A reply is registered and reaches rsp_valid in the cycle after it is formed.
// After reset, and after every register write, all MAX_FRAMES entries of the
// received map are cleared at one entry a cycle, while req_ready is held low.
// When rsp_ready is low the sequencer waits, the queue fills, and req_ready
// drops once it holds two frames.
// ----------------------------------------------------------------------------
module selective_repeat_receiver #(
   parameter int MAX_FRAMES = srr_pkg::MAX_FRAMES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [srr_pkg::DATA_W-1:0]     req_data_byte,
   input  logic                          req_last_byte,
   input  logic [srr_pkg::FRAME_W-1:0]    req_frame_number,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [srr_pkg::KIND_W-1:0]     rsp_reply_kind,
   output logic [srr_pkg::FRAME_W-1:0]    rsp_reply_frame,
   output logic                          rsp_last_reply,
   output logic                          rsp_session_done,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [srr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [srr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [srr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready
);
   import srr_pkg::*;

   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [WINDOW_W-1:0] window_ff, window_in;
   logic                csr_wr;
   cfg_type             cfg_bus;

   logic               clearing;
   logic               queue_full;
   logic               push;
   logic [FRAME_W-1:0] push_number;
   logic               q_valid;
   logic [FRAME_W-1:0] q_number;
   logic               q_pop;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      total_in  = total_ff;
      window_in = window_ff;
      if (csr_wr) begin
         unique case (csr_paddr[REG_BIT])
            REG_TOTAL: begin
               total_in = csr_pwdata[TOTAL_W-1:0];
            end
            REG_WINDOW: begin
               window_in = csr_pwdata[WINDOW_W-1:0];
            end
            default: begin
               total_in = total_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[REG_BIT])
         REG_TOTAL: begin
            csr_prdata = CSR_DATA_W'(total_ff);
         end
         REG_WINDOW: begin
            csr_prdata = CSR_DATA_W'(window_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff  <= TOTAL_W'(TOTAL_RESET_VAL);
         window_ff <= WINDOW_W'(WINDOW_RESET_VAL);
      end else begin
         total_ff  <= total_in;
         window_ff <= window_in;
      end
   end

   assign cfg_bus.restart      = csr_wr;
   assign cfg_bus.total_frames = total_in;
   assign cfg_bus.window_size  = window_in;

   srr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .restart          (cfg_bus.restart),
      .clearing         (clearing),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .req_frame_number (req_frame_number),
      .queue_full       (queue_full),
      .push             (push),
      .push_number      (push_number)
   );

   srr_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .flush       (cfg_bus.restart),
      .push        (push),
      .push_number (push_number),
      .pop         (q_pop),
      .full        (queue_full),
      .head_valid  (q_valid),
      .head_number (q_number)
   );

   srr_back #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_bus),
      .q_valid          (q_valid),
      .q_number         (q_number),
      .q_pop            (q_pop),
      .clearing         (clearing),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_reply_kind   (rsp_reply_kind),
      .rsp_reply_frame  (rsp_reply_frame),
      .rsp_last_reply   (rsp_last_reply),
      .rsp_session_done (rsp_session_done)
   );

   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_ready)
      else $error("Input accepted while the received map is being cleared.");

   a_restart_starts_clear: assert property (@(posedge clock) disable iff (reset)
      cfg_bus.restart |=> clearing)
      else $error("Register write did not start a clearing pass.");

   a_nak_not_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_reply_kind == KIND_NAK)) |-> !rsp_last_reply)
      else $error("NAK reply marked as the final reply of a frame.");

   a_pop_only_when_queued: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("Frame taken from an empty queue.");

endmodule
`default_nettype wire

@@ verif/tb_selective_repeat_receiver.sv @@
// ----------------------------------------------------------------------------
// tb_selective_repeat_receiver: self-checking bench for the ARQ receiver
// Frames are sent as byte transfers with good or damaged check bytes and
// with sequence numbers chosen around the next expected number. A reply
// board predicts every ACK, NAK and reject reply from its own copy of the
// window state and compares each reply transfer with the oldest prediction.
// The session registers are rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_selective_repeat_receiver;
   timeunit 1ns;
   timeprecision 1ps;
   import srr_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int IDLE_PERCENT  = 23;
   localparam int SETTLE_CYCLES = MAX_FRAMES_DEF + 200;
   localparam int RANDOM_PHASES = 6;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [FRAME_W-1:0] frame;
      logic               last;
      logic               done;
   } reply_type;

   class reply_board;
      reply_type   pending_replies[$];
      int          errors;
      int unsigned total_reg;
      int unsigned window_reg;
      logic [7:0]  check_acc;
      bit          received_map [MAX_FRAMES_DEF];
      int          next_expected;
      int          window_low;
      int          window_high;
      bit          finished;

      function new();
         errors     = 0;
         total_reg  = TOTAL_RESET_VAL;
         window_reg = WINDOW_RESET_VAL;
         restart();
      endfunction

      function int frames_in_use();
         if (total_reg == 0) return 1;
         if (total_reg > MAX_FRAMES_DEF) return MAX_FRAMES_DEF;
         return total_reg;
      endfunction

      function void restart();
         int ws;
         int tf;
         ws = (window_reg == 0) ? 1 : window_reg;
         tf = frames_in_use();
         check_acc = '0;
         foreach (received_map[i]) received_map[i] = 1'b0;
         next_expected = 0;
         window_low    = 0;
         window_high   = (ws - 1 < tf - 1) ? ws - 1 : tf - 1;
         finished      = 1'b0;
      endfunction

      function void load_register(logic idx, logic [CSR_DATA_W-1:0] value);
         if (idx == REG_TOTAL) begin
            total_reg = value & ((1 << TOTAL_W) - 1);
         end else begin
            window_reg = value & ((1 << WINDOW_W) - 1);
         end
         restart();
      endfunction

      function void slide_window();
         int tf;
         tf = frames_in_use();
         while (window_low <= window_high && window_low < tf &&
                received_map[window_low]) begin
            window_low++;
            if (window_high < tf - 1) window_high++;
         end
         finished = (window_low == window_high + 1);
      endfunction

      function void push_reply(logic [KIND_W-1:0] kind, int frame, logic last);
         reply_type r;
         r.kind  = kind;
         r.frame = frame[FRAME_W-1:0];
         r.last  = last;
         r.done  = finished;
         pending_replies.push_back(r);
      endfunction

      function void note_byte(logic [DATA_W-1:0] data, logic last,
                              logic [FRAME_W-1:0] number);
         int n;
         int k;
         bit good;
         n = int'(number);
         if (!last) begin
            check_acc ^= data;
            return;
         end
         good      = (check_acc == data);
         check_acc = '0;
         if (!good) return;
         if (n >= frames_in_use() ||
             (n > next_expected && n - next_expected > MAX_GAP)) begin
            push_reply(KIND_REJECT, n, 1'b1);
            return;
         end
         received_map[n] = 1'b1;
         if (n == next_expected) begin
            slide_window();
            next_expected++;
            push_reply(KIND_ACK, n, 1'b1);
         end else if (n > next_expected) begin
            for (k = next_expected; k < n; k++) push_reply(KIND_NAK, k, 1'b0);
            push_reply(KIND_ACK, n, 1'b1);
            next_expected = n + 1;
         end else begin
            slide_window();
            push_reply(KIND_ACK, n, 1'b1);
         end
      endfunction

      function void check_reply(logic [KIND_W-1:0] kind, logic [FRAME_W-1:0] frame,
                                logic last, logic done);
         reply_type exp;
         if (pending_replies.size() == 0) begin
            $error("unexpected reply: reply_kind %0d reply_frame %0d", kind, frame);
            errors++;
            return;
         end
         exp = pending_replies.pop_front();
         if (kind !== exp.kind) begin
            $error("reply_kind: expected %0d, actual %0d", exp.kind, kind);
            errors++;
         end
         if (frame !== exp.frame) begin
            $error("reply_frame: expected %0d, actual %0d", exp.frame, frame);
            errors++;
         end
         if (last !== exp.last) begin
            $error("last_reply: expected %0d, actual %0d", exp.last, last);
            errors++;
         end
         if (done !== exp.done) begin
            $error("session_done: expected %0d, actual %0d", exp.done, done);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [DATA_W-1:0]     req_data_byte = '0;
   logic                  req_last_byte = 1'b0;
   logic [FRAME_W-1:0]    req_frame_number = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [KIND_W-1:0]     rsp_reply_kind;
   logic [FRAME_W-1:0]    rsp_reply_frame;
   logic                  rsp_last_reply;
   logic                  rsp_session_done;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   reply_board board;
   bit         calm = 1'b0;
   int         bytes_sent = 0;

   selective_repeat_receiver u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .req_frame_number (req_frame_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_reply_kind   (rsp_reply_kind),
      .rsp_reply_frame  (rsp_reply_frame),
      .rsp_last_reply   (rsp_last_reply),
      .rsp_session_done (rsp_session_done),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_reply(rsp_reply_kind, rsp_reply_frame, rsp_last_reply,
                           rsp_session_done);
      end
      rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   task automatic send_byte(logic [DATA_W-1:0] data, logic last,
                            logic [FRAME_W-1:0] number);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= data;
      req_last_byte    <= last;
      req_frame_number <= number;
      do @(posedge clock); while (!req_ready);
      board.note_byte(data, last, number);
      bytes_sent++;
   endtask

   task automatic send_frame(int data_count, bit good, logic [FRAME_W-1:0] number);
      logic [DATA_W-1:0] acc;
      logic [DATA_W-1:0] data;
      acc = '0;
      repeat (data_count) begin
         data = DATA_W'($urandom);
         acc ^= data;
         send_byte(data, 1'b0, FRAME_W'($urandom));
      end
      if (!good) acc ^= DATA_W'($urandom_range(1, 255));
      send_byte(acc, 1'b1, number);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (board.pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic idx, logic [CSR_DATA_W-1:0] value);
      logic [CSR_ADDR_W-1:0] addr;
      addr          = '0;
      addr[REG_BIT] = idx;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      board.load_register(idx, value);
      @(posedge clock);
   endtask

   function automatic logic [FRAME_W-1:0] pick_frame_number();
      int ne;
      int r;
      ne = board.next_expected;
      r  = $urandom_range(0, 99);
      if (r < 40) return FRAME_W'(ne);
      if (r < 65) return FRAME_W'(ne + $urandom_range(1, 6));
      if (r < 80) return (ne > 0) ? FRAME_W'($urandom_range(0, ne - 1)) : FRAME_W'(ne);
      if (r < 88) return FRAME_W'(ne + $urandom_range(7, MAX_GAP));
      if (r < 94) return FRAME_W'(ne + MAX_GAP + $urandom_range(1, 4));
      return FRAME_W'($urandom);
   endfunction

   initial begin
      int          phase;
      int          budget;
      int          start_count;
      int          r;
      logic [31:0] total_value;
      logic [31:0] window_value;
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset session: frame 0, a reject, a bad check, then a late frame 0.
      send_frame(0, 1'b1, 0);
      send_frame(1, 1'b1, 1);
      send_frame(2, 1'b0, 0);
      send_byte(8'hFF, 1'b0, 12'hFFF);
      send_byte(8'hFF, 1'b1, 12'd0);

      wait_quiet();
      write_register(REG_TOTAL, 32'd6);
      write_register(REG_WINDOW, 32'd2);
      send_frame(0, 1'b1, 0);
      send_frame(0, 1'b1, 3);
      send_frame(0, 1'b1, 1);
      send_frame(1, 1'b1, 2);
      send_frame(0, 1'b1, 4);
      send_frame(0, 1'b1, 5);

      wait_quiet();
      write_register(REG_TOTAL, 32'hFFFF_E000);
      write_register(REG_WINDOW, 32'hFFFF_FFC0);
      send_frame(0, 1'b1, 0);
      send_frame(0, 1'b1, 1);

      wait_quiet();
      write_register(REG_TOTAL, 32'h0000_1FFF);
      write_register(REG_WINDOW, 32'd63);
      send_frame(0, 1'b1, FRAME_W'(MAX_GAP + 1));
      send_frame(0, 1'b1, FRAME_W'(MAX_GAP));
      send_frame(1, 1'b1, 4095);
      send_frame(0, 1'b1, 0);

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         r = $urandom_range(0, 99);
         if (r < 40) total_value = $urandom_range(1, 24);
         else if (r < 80) total_value = $urandom_range(25, 300);
         else if (r < 90) total_value = $urandom_range(301, MAX_FRAMES_DEF);
         else total_value = $urandom_range(MAX_FRAMES_DEF + 1, (1 << TOTAL_W) - 1);
         r = $urandom_range(0, 99);
         if (r < 15) window_value = 63;
         else if (r < 25) window_value = 0;
         else if (r < 35) window_value = 1;
         else window_value = $urandom_range(2, 62);
         total_value  = ($urandom & ~((1 << TOTAL_W) - 1)) | total_value;
         window_value = ($urandom & ~((1 << WINDOW_W) - 1)) | window_value;
         wait_quiet();
         write_register(REG_TOTAL, total_value);
         write_register(REG_WINDOW, window_value);
         calm <= (phase == 3);
         budget      = (phase == 3) ? 60 : 28;
         start_count = bytes_sent;
         while (bytes_sent - start_count < budget) begin
            send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(4, 10)
                                                   : $urandom_range(0, 2),
                       $urandom_range(0, 99) >= 12, pick_frame_number());
         end
      end

      calm <= 1'b0;
      wait_quiet();
      if (board.errors == 0) begin
         $display("PASS selective_repeat_receiver");
      end else begin
         $display("FAIL selective_repeat_receiver");
      end
      $finish;
   end

   initial begin
      #12_000_000;
      $display("FAIL selective_repeat_receiver");
      $finish;
   end

endmodule

@@ filelist.f @@
src/srr_pkg.sv
src/srr_fifo.sv
src/srr_front.sv
src/srr_back.sv
src/selective_repeat_receiver.sv
verif/tb_selective_repeat_receiver.sv
